FILE: rtl/ifwa_pkg.sv
// Package for the interlaced field weave assembler.
// Widths, limits, field codes, register indexes and controller/datapath structs.
// No dependencies.
`default_nettype none
package ifwa_pkg;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 12;
   localparam int IDX_W    = 12;
   localparam int LB_W     = 12;
   localparam int FL_W     = 11;
   localparam int LINE_W   = 11;
   localparam int COL_W    = 11;
   localparam int ADDR_W   = 21;
   localparam int FSIZE_W  = 22;
   localparam int FIELD_W  = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;
   localparam int REM_CNT_W  = 5;
   localparam int REM_STEPS  = ADDR_W;

   localparam int MAX_LINE_BYTES   = 2048;
   localparam int MAX_FRAME_LINES  = 1024;
   localparam int MAX_PACKET_BYTES = 3072;
   localparam int MIN_LINE_BYTES   = 2;
   localparam int MIN_FRAME_LINES  = 2;

   localparam int LB_RESET    = 1440;
   localparam int FL_RESET    = 576;
   localparam int FSIZE_RESET = LB_RESET * FL_RESET;

   localparam int PAYLOAD_OFFSET = 4;
   localparam int CTRL_PKT_LEN   = 8;
   localparam int LINE_COUNT_MAX = 2047;
   localparam logic [ADDR_W-1:0] BASE_LIMIT = {ADDR_W{1'b1}};

   localparam logic [BYTE_W-1:0] MARK_FIELD2_A = 8'h40;
   localparam logic [BYTE_W-1:0] MARK_FIELD2_B = 8'hC0;
   localparam logic [BYTE_W-1:0] MARK_FIELD2_C = 8'hE0;

   localparam logic [FIELD_W-1:0] FIELD_NONE = 2'd0;
   localparam logic [FIELD_W-1:0] FIELD_ONE  = 2'd1;
   localparam logic [FIELD_W-1:0] FIELD_TWO  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_BYTES  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LINES = 1'd1;

   typedef struct packed {
      logic load;
      logic pre;
      logic post;
      logic mod_start;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_mod;
      logic mod_done;
   } ctrl_sts_type;

endpackage
`default_nettype wire

FILE: rtl/ifwa_if.sv
// Channel interfaces of the weave assembler: packet bytes in, frame writes out.
// Depends on ifwa_pkg.
`default_nettype none
interface ifwa_req_if
   import ifwa_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  data_byte;
   logic               packet_start;
   logic               packet_end;
   logic [LEN_W-1:0]   packet_length;

   modport source (output valid, data_byte, packet_start, packet_end, packet_length,
                   input ready);
   modport sink   (input valid, data_byte, packet_start, packet_end, packet_length,
                   output ready);
endinterface

interface ifwa_rsp_if
   import ifwa_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  write_address;
   logic [BYTE_W-1:0]  write_data;
   logic               write_enable;
   logic               frame_done;

   modport source (output valid, write_address, write_data, write_enable, frame_done,
                   input ready);
   modport sink   (input valid, write_address, write_data, write_enable, frame_done,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/interlaced_field_weave_assembler_top.sv
// Top level of the interlaced field weave assembler.
// Depends on ifwa_pkg, ifwa_if, ifwa_ctrl and ifwa_datapath.
//
// Usage:
//   req_if carries one packet byte per item with its start/end flags and the
//   packet length; rsp_if gives exactly one frame-memory write per item
//   (address, data, enable) plus frame_done at the end of a completed frame.
//   csr_write_enable/csr_index/csr_write_data set line_bytes (index 0) and
//   frame_lines (index 1); write them only while the block is idle.
//   Each item is registered on acceptance, then passes the pre and post
//   compute steps; post writes its result. A new item is taken only once
//   the last one has left post. On the last byte of a payload packet that
//   does not complete the frame, the line base is wrapped modulo the frame
//   size by a bit-serial remainder unit before the next item is taken.
//   Reset: line_bytes = 1440, frame_lines = 576, all field, line, column and
//   byte counters cleared, no result pending.
//   Stall: a result waits in the output register while rsp_if.ready is low;
//   the next item is still accepted and computed up to the point of writing
//   its result, then held until the register is free.
`default_nettype none
module interlaced_field_weave_assembler_top
   import ifwa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   ifwa_req_if.sink                   req_if,
   ifwa_rsp_if.source                 rsp_if,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   ifwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ifwa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .in_data_byte      (req_if.data_byte),
      .in_packet_start   (req_if.packet_start),
      .in_packet_end     (req_if.packet_end),
      .in_packet_length  (req_if.packet_length),
      .cmd               (cmd),
      .sts               (sts),
      .out_write_address (rsp_if.write_address),
      .out_write_data    (rsp_if.write_data),
      .out_write_enable  (rsp_if.write_enable),
      .out_frame_done    (rsp_if.frame_done)
   );

endmodule
`default_nettype wire

FILE: rtl/ifwa_rem.sv
// Restoring remainder unit, one quotient bit per cycle.
// Used to wrap the line base modulo the frame size. Depends on ifwa_pkg.
`default_nettype none
module ifwa_rem
   import ifwa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [ADDR_W-1:0]  dividend,
   input  wire logic [FSIZE_W-1:0] divisor,
   output logic                    done,
   output logic [ADDR_W-1:0]       remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0]    rem_ff, rem_in;
   logic [ADDR_W-1:0]    shf_ff, shf_in;
   logic [FSIZE_W-1:0]   trial;

   always_comb begin
      trial   = {rem_ff, shf_ff[ADDR_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = REM_CNT_W'(REM_STEPS);
         rem_in  = '0;
         shf_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= divisor) begin
            rem_in = ADDR_W'(trial - divisor);
         end else begin
            rem_in = trial[ADDR_W-1:0];
         end
         shf_in = {shf_ff[ADDR_W-2:0], 1'b0};
         cnt_in = cnt_ff - REM_CNT_W'(1);
         if (cnt_ff == REM_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

FILE: rtl/ifwa_datapath.sv
// Datapath of the weave assembler: configuration, field/line/column state,
// address generation, result register and the line base remainder unit.
// Depends on ifwa_pkg and ifwa_rem.
`default_nettype none
module ifwa_datapath
   import ifwa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   input  wire logic [BYTE_W-1:0]     in_data_byte,
   input  wire logic                  in_packet_start,
   input  wire logic                  in_packet_end,
   input  wire logic [LEN_W-1:0]      in_packet_length,
   input  wire ctrl_cmd_type          cmd,
   output ctrl_sts_type               sts,
   output logic [ADDR_W-1:0]          out_write_address,
   output logic [BYTE_W-1:0]          out_write_data,
   output logic                       out_write_enable,
   output logic                       out_frame_done
);

   logic [LB_W-1:0]    csr_lb_ff, csr_lb_in;
   logic [FL_W-1:0]    csr_fl_ff, csr_fl_in;
   logic [LB_W-1:0]    lb_ff, lb_in;
   logic [FL_W-1:0]    fl_ff, fl_in;
   logic [FSIZE_W-1:0] fsize_ff, fsize_in;
   logic [FSIZE_W:0]   fsize_prod;

   logic [BYTE_W-1:0]  byte_ff;
   logic               start_ff, end_ff;
   logic [LEN_W-1:0]   len_ff;

   logic [FIELD_W-1:0] prev_field_ff, prev_field_in;
   logic [LINE_W-1:0]  line_count_ff, line_count_in;
   logic [COL_W-1:0]   column_ff, column_in;
   logic [ADDR_W-1:0]  line_base_ff, line_base_in;
   logic [IDX_W-1:0]   byte_index_ff, byte_index_in;
   logic               pay_ff, pay_in;
   logic               pkt_ff, pkt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [BYTE_W-1:0]  data_ff, data_in;
   logic               wen_ff, wen_in;
   logic               done_ff, done_in;

   logic [IDX_W-1:0]   idx;
   logic [FIELD_W-1:0] fld;
   logic [COL_W-1:0]   col0, pre_col, post_col;
   logic [LINE_W-1:0]  lc0, pre_lc, post_lc;
   logic [ADDR_W-1:0]  base0, pre_base, post_base;
   logic               pkt, pay;
   logic [FSIZE_W-1:0] addr_sum;
   logic [COL_W:0]     col_inc;
   logic [LINE_W:0]    lc_plus;
   logic [IDX_W:0]     idx_inc;
   logic [IDX_W-1:0]   byte_next;
   logic               frame_end;
   logic               mod_done;
   logic [ADDR_W-1:0]  rem;

   function automatic logic [ADDR_W-1:0] next_base(input logic [ADDR_W-1:0] base,
                                                   input logic [LB_W-1:0] lb);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {(ADDR_W-LB_W)'(0), lb, 1'b0};
      return sum[ADDR_W] ? BASE_LIMIT : sum[ADDR_W-1:0];
   endfunction

   function automatic logic [LINE_W-1:0] next_line(input logic [LINE_W-1:0] lc);
      logic [LINE_W:0] sum;
      sum = {1'b0, lc} + (LINE_W+1)'(2);
      return (sum > (LINE_W+1)'(LINE_COUNT_MAX)) ? LINE_W'(LINE_COUNT_MAX)
                                                  : sum[LINE_W-1:0];
   endfunction

   always_comb begin
      csr_lb_in = csr_lb_ff;
      csr_fl_in = csr_fl_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LINE_BYTES:  csr_lb_in = csr_write_data[LB_W-1:0];
            CSR_FRAME_LINES: csr_fl_in = csr_write_data[FL_W-1:0];
            default: ;
         endcase
      end
      if (csr_lb_ff < LB_W'(MIN_LINE_BYTES)) begin
         lb_in = LB_W'(MIN_LINE_BYTES);
      end else if (csr_lb_ff > LB_W'(MAX_LINE_BYTES)) begin
         lb_in = LB_W'(MAX_LINE_BYTES);
      end else begin
         lb_in = csr_lb_ff;
      end
      if (csr_fl_ff < FL_W'(MIN_FRAME_LINES)) begin
         fl_in = FL_W'(MIN_FRAME_LINES);
      end else if (csr_fl_ff > FL_W'(MAX_FRAME_LINES)) begin
         fl_in = FL_W'(MAX_FRAME_LINES);
      end else begin
         fl_in = csr_fl_ff;
      end
      fsize_prod = {(FSIZE_W+1-LB_W)'(0), lb_ff} * {(FSIZE_W+1-FL_W)'(0), fl_ff};
      fsize_in   = fsize_prod[FSIZE_W-1:0];
   end

   always_comb begin
      idx = start_ff ? '0 : byte_index_ff;
      fld = (byte_ff == MARK_FIELD2_A || byte_ff == MARK_FIELD2_B ||
             byte_ff == MARK_FIELD2_C) ? FIELD_TWO : FIELD_ONE;
      col0  = column_ff;
      lc0   = line_count_ff;
      base0 = line_base_ff;
      if (start_ff) begin
         if (prev_field_ff == FIELD_TWO && fld == FIELD_ONE) begin
            col0  = COL_W'(1);
            lc0   = '0;
            base0 = '0;
         end
         if (prev_field_ff == FIELD_ONE && fld == FIELD_TWO) begin
            col0  = COL_W'(1);
            lc0   = LINE_W'(1);
            base0 = {(ADDR_W-LB_W)'(0), lb_ff};
         end
      end
      pkt = (len_ff > LEN_W'(PAYLOAD_OFFSET)) && (len_ff != LEN_W'(CTRL_PKT_LEN));
      pay = pkt && (idx >= IDX_W'(PAYLOAD_OFFSET)) && (idx < len_ff) &&
            (idx < IDX_W'(MAX_PACKET_BYTES));
      pre_col  = col0;
      pre_lc   = lc0;
      pre_base = base0;
      if (pay && ({1'b0, col0} >= lb_ff)) begin
         pre_base = next_base(base0, lb_ff);
         pre_lc   = next_line(lc0);
         pre_col  = '0;
      end
   end

   always_comb begin
      addr_sum  = {1'b0, line_base_ff} + {(FSIZE_W-COL_W)'(0), column_ff};
      col_inc   = {1'b0, column_ff} + (COL_W+1)'(1);
      post_col  = column_ff;
      post_lc   = line_count_ff;
      post_base = line_base_ff;
      if (pay_ff) begin
         if (col_inc >= lb_ff) begin
            post_base = next_base(line_base_ff, lb_ff);
            post_lc   = next_line(line_count_ff);
            post_col  = '0;
         end else begin
            post_col = col_inc[COL_W-1:0];
         end
      end
      lc_plus   = {1'b0, post_lc} + (LINE_W+1)'(1);
      frame_end = end_ff && pkt_ff && (lc_plus >= {1'b0, fl_ff});
      idx_inc   = {1'b0, idx_ff} + (IDX_W+1)'(1);
      if (end_ff) begin
         byte_next = '0;
      end else if (idx_inc > (IDX_W+1)'(MAX_PACKET_BYTES)) begin
         byte_next = IDX_W'(MAX_PACKET_BYTES);
      end else begin
         byte_next = idx_inc[IDX_W-1:0];
      end
   end

   always_comb begin
      prev_field_in = prev_field_ff;
      line_count_in = line_count_ff;
      column_in     = column_ff;
      line_base_in  = line_base_ff;
      byte_index_in = byte_index_ff;
      pay_in  = pay_ff;
      pkt_in  = pkt_ff;
      idx_in  = idx_ff;
      addr_in = addr_ff;
      data_in = data_ff;
      wen_in  = wen_ff;
      done_in = done_ff;
      if (cmd.pre) begin
         if (start_ff) begin
            prev_field_in = fld;
         end
         line_count_in = pre_lc;
         column_in     = pre_col;
         line_base_in  = pre_base;
         pay_in = pay;
         pkt_in = pkt;
         idx_in = idx;
      end
      if (cmd.post) begin
         byte_index_in = byte_next;
         addr_in = pay_ff ? addr_sum[ADDR_W-1:0] : '0;
         data_in = pay_ff ? byte_ff : '0;
         wen_in  = pay_ff && (addr_sum < fsize_ff);
         done_in = frame_end;
         if (frame_end) begin
            line_count_in = '0;
            column_in     = '0;
            line_base_in  = '0;
         end else begin
            line_count_in = post_lc;
            column_in     = post_col;
            line_base_in  = post_base;
         end
      end
      if (mod_done) begin
         line_base_in = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_lb_ff     <= LB_W'(LB_RESET);
         csr_fl_ff     <= FL_W'(FL_RESET);
         lb_ff         <= LB_W'(LB_RESET);
         fl_ff         <= FL_W'(FL_RESET);
         fsize_ff      <= FSIZE_W'(FSIZE_RESET);
         prev_field_ff <= FIELD_NONE;
         line_count_ff <= '0;
         column_ff     <= '0;
         line_base_ff  <= '0;
         byte_index_ff <= '0;
      end else begin
         csr_lb_ff     <= csr_lb_in;
         csr_fl_ff     <= csr_fl_in;
         lb_ff         <= lb_in;
         fl_ff         <= fl_in;
         fsize_ff      <= fsize_in;
         prev_field_ff <= prev_field_in;
         line_count_ff <= line_count_in;
         column_ff     <= column_in;
         line_base_ff  <= line_base_in;
         byte_index_ff <= byte_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff  <= in_data_byte;
         start_ff <= in_packet_start;
         end_ff   <= in_packet_end;
         len_ff   <= in_packet_length;
      end
      pay_ff  <= pay_in;
      pkt_ff  <= pkt_in;
      idx_ff  <= idx_in;
      addr_ff <= addr_in;
      data_ff <= data_in;
      wen_ff  <= wen_in;
      done_ff <= done_in;
   end

   ifwa_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (post_base),
      .divisor   (fsize_ff),
      .done      (mod_done),
      .remainder (rem)
   );

   assign sts.need_mod = end_ff && pkt_ff && !frame_end;
   assign sts.mod_done = mod_done;

   assign out_write_address = addr_ff;
   assign out_write_data    = data_ff;
   assign out_write_enable  = wen_ff;
   assign out_frame_done    = done_ff;

endmodule
`default_nettype wire

FILE: rtl/ifwa_ctrl.sv
// Controller of the weave assembler: accept, two compute steps, line base wrap,
// and the valid flag of the result register. Depends on ifwa_pkg.
`default_nettype none
module ifwa_ctrl
   import ifwa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire ctrl_sts_type sts,
   output ctrl_cmd_type      cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PRE  = 2'd1;
   localparam logic [1:0] S_POST = 2'd2;
   localparam logic [1:0] S_MODW = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       slot_free;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      slot_free = !out_valid_ff || rsp_ready;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            cmd.pre  = 1'b1;
            state_in = S_POST;
         end
         S_POST: begin
            if (slot_free) begin
               cmd.post = 1'b1;
               if (sts.need_mod) begin
                  cmd.mod_start = 1'b1;
                  state_in      = S_MODW;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MODW: begin
            if (sts.mod_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      out_valid_in = (out_valid_ff && !rsp_ready) || cmd.post;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> out_valid_ff)
      else $error("pending result dropped");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.post |-> (!out_valid_ff || rsp_ready))
      else $error("result register overwritten while full");

   a_wrap_only_waiting: assert property (@(posedge clock) disable iff (reset)
      sts.mod_done |-> (state_ff == S_MODW))
      else $error("line base wrap finished outside its wait state");

   a_pre_then_post: assert property (@(posedge clock) disable iff (reset)
      cmd.pre |=> (state_ff == S_POST))
      else $error("compute step skipped");

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for interlaced_field_weave_assembler_top.
// Packet bytes are driven through the request interface; every frame write is checked
// against an in-bench model of the field weave. Depends on ifwa_pkg and ifwa_if.
module testbench
   import ifwa_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PRINT_CAP    = 100;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              packet_start;
      logic              packet_end;
      logic [LEN_W-1:0]  packet_length;
   } packet_byte_type;

   typedef struct packed {
      logic [ADDR_W-1:0] write_address;
      logic [BYTE_W-1:0] write_data;
      logic              write_enable;
      logic              frame_done;
   } frame_write_type;

   typedef enum int {FLOW_FREE, FLOW_RANDOM, FLOW_PULSED} flow_mode_type;

   class weave_tracker;
      frame_write_type pending_writes[$];
      int unsigned  errors;
      int unsigned  line_bytes_reg, frame_lines_reg;
      logic [FIELD_W-1:0] field_seen;
      int unsigned  line_no, col, base, byte_pos;

      function new();
         line_bytes_reg  = LB_RESET;
         frame_lines_reg = FL_RESET;
         field_seen      = FIELD_NONE;
         line_no  = 0;
         col      = 0;
         base     = 0;
         byte_pos = 0;
         errors   = 0;
      endfunction

      function int unsigned pending();
         return pending_writes.size();
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_LINE_BYTES)
            line_bytes_reg = data;
         else
            frame_lines_reg = data[FL_W-1:0];
      endfunction

      function void close_line(int unsigned lb);
         int unsigned nb;
         nb = base + 2 * lb;
         base = (nb > BASE_LIMIT) ? BASE_LIMIT : nb;
         line_no = (line_no + 2 > LINE_COUNT_MAX) ? LINE_COUNT_MAX : line_no + 2;
         col = 0;
      endfunction

      function void note_byte(packet_byte_type it);
         int unsigned lb, fl, fsize, idx, a;
         logic [FIELD_W-1:0] fld;
         bit payload_pkt;
         frame_write_type w;
         lb = (line_bytes_reg < MIN_LINE_BYTES) ? MIN_LINE_BYTES :
              (line_bytes_reg > MAX_LINE_BYTES) ? MAX_LINE_BYTES : line_bytes_reg;
         fl = (frame_lines_reg < MIN_FRAME_LINES) ? MIN_FRAME_LINES :
              (frame_lines_reg > MAX_FRAME_LINES) ? MAX_FRAME_LINES : frame_lines_reg;
         fsize = lb * fl;
         if (fsize > 2 ** ADDR_W) fsize = 2 ** ADDR_W;
         idx = it.packet_start ? 0 : byte_pos;
         payload_pkt = (it.packet_length > PAYLOAD_OFFSET) && (it.packet_length != CTRL_PKT_LEN);
         w = '0;
         if (it.packet_start) begin
            fld = (it.data_byte == MARK_FIELD2_A || it.data_byte == MARK_FIELD2_B ||
                   it.data_byte == MARK_FIELD2_C) ? FIELD_TWO : FIELD_ONE;
            if (field_seen == FIELD_TWO && fld == FIELD_ONE) begin
               col = 1;
               line_no = 0;
               base = 0;
            end
            if (field_seen == FIELD_ONE && fld == FIELD_TWO) begin
               col = 1;
               line_no = 1;
               base = lb;
            end
            field_seen = fld;
         end
         if (payload_pkt && idx >= PAYLOAD_OFFSET && idx < it.packet_length &&
             idx < MAX_PACKET_BYTES) begin
            if (col >= lb) close_line(lb);
            a = base + col;
            w.write_data    = it.data_byte;
            w.write_address = a[ADDR_W-1:0];
            w.write_enable  = (a < fsize);
            col++;
            if (col >= lb) close_line(lb);
         end
         if (it.packet_end) begin
            if (payload_pkt) begin
               base = base % fsize;
               if (line_no + 1 >= fl) begin
                  w.frame_done = 1'b1;
                  line_no = 0;
                  col = 0;
                  base = 0;
               end
            end
            byte_pos = 0;
         end else begin
            byte_pos = (idx + 1 > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : idx + 1;
         end
         pending_writes.push_back(w);
      endfunction

      task report(string what);
         errors++;
         if (errors <= PRINT_CAP)
            $display("%0t mismatch: %s", $time, what);
      endtask

      task check_write(frame_write_type got);
         frame_write_type want;
         if (pending_writes.size() == 0) begin
            report($sformatf("write %h with nothing expected", got));
         end else begin
            want = pending_writes.pop_front();
            if (got.write_address !== want.write_address)
               report($sformatf("write_address %h, expected %h",
                                got.write_address, want.write_address));
            if (got.write_data !== want.write_data)
               report($sformatf("write_data %h, expected %h", got.write_data, want.write_data));
            if (got.write_enable !== want.write_enable)
               report($sformatf("write_enable %b, expected %b",
                                got.write_enable, want.write_enable));
            if (got.frame_done !== want.frame_done)
               report($sformatf("frame_done %b, expected %b", got.frame_done, want.frame_done));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   ifwa_req_if req ();
   ifwa_rsp_if rsp ();

   interlaced_field_weave_assembler_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req),
      .rsp_if           (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   weave_tracker board = new();
   int unsigned  bytes_sent;
   int unsigned  burst_left;
   bit           second_field;

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      packet_byte_type taken;
      frame_write_type seen;
      if (!reset && req.valid && req.ready) begin
         taken.data_byte     = req.data_byte;
         taken.packet_start  = req.packet_start;
         taken.packet_end    = req.packet_end;
         taken.packet_length = req.packet_length;
         board.note_byte(taken);
      end
      if (!reset && rsp.valid && rsp.ready) begin
         seen.write_address = rsp.write_address;
         seen.write_data    = rsp.write_data;
         seen.write_enable  = rsp.write_enable;
         seen.frame_done    = rsp.frame_done;
         board.check_write(seen);
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      flow_mode_type mode;
      int unsigned span, tick;
      rsp.ready <= 1'b0;
      mode = FLOW_FREE;
      span = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            mode = flow_mode_type'($urandom_range(0, 2));
            span = $urandom_range(16, 160);
         end
         span--;
         tick++;
         case (mode)
            FLOW_FREE:   rsp.ready <= 1'b1;
            FLOW_RANDOM: rsp.ready <= ($urandom_range(0, 3) != 0);
            default:     rsp.ready <= ((tick % 9) > 4);
         endcase
      end
   end

   task automatic send_byte(input packet_byte_type it);
      @(negedge clock);
      if (burst_left == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(1, 24);
      end
      req.valid         <= 1'b1;
      req.data_byte     <= it.data_byte;
      req.packet_start  <= it.packet_start;
      req.packet_end    <= it.packet_end;
      req.packet_length <= it.packet_length;
      burst_left--;
      bytes_sent++;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic send_packet(input logic [BYTE_W-1:0] lead, input int unsigned len_field,
                              input int unsigned count, input bit with_start,
                              input bit with_end, input int fill);
      packet_byte_type it;
      for (int unsigned i = 0; i < count; i++) begin
         it.data_byte     = (i == 0) ? lead : (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
         it.packet_start  = with_start && (i == 0);
         it.packet_end    = with_end && (i == count - 1);
         it.packet_length = LEN_W'(len_field);
         send_byte(it);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req.valid <= 1'b0;
      burst_left = 0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index, input int unsigned data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= CSR_DATA_W'(data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.set_register(index, CSR_DATA_W'(data));
   endtask

   task automatic reconfigure(input int unsigned lb, input int unsigned fl);
      settle();
      write_register(CSR_LINE_BYTES, lb);
      write_register(CSR_FRAME_LINES, fl);
   endtask

   function automatic logic [BYTE_W-1:0] field_lead(input bit second);
      logic [BYTE_W-1:0] b;
      case ($urandom_range(0, 2))
         0:       b = MARK_FIELD2_A;
         1:       b = MARK_FIELD2_B;
         default: b = MARK_FIELD2_C;
      endcase
      if (!second) begin
         do b = BYTE_W'($urandom);
         while (b == MARK_FIELD2_A || b == MARK_FIELD2_B || b == MARK_FIELD2_C);
      end
      return b;
   endfunction

   task automatic random_traffic(input int unsigned quota);
      int unsigned stop_at, pick, len;
      stop_at = bytes_sent + quota;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 15) second_field = !second_field;
         if (pick < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 300) : $urandom_range(5, 40);
            if (len == CTRL_PKT_LEN) len++;
            send_packet(field_lead(second_field), len, len, 1'b1, 1'b1, -1);
         end else if (pick < 76) begin
            len = $urandom_range(0, PAYLOAD_OFFSET);
            if (len == 0) len = CTRL_PKT_LEN;
            send_packet(field_lead(second_field), len, len, 1'b1, 1'b1, -1);
         end else if (pick < 80) begin
            send_packet(field_lead(second_field), 0, $urandom_range(1, 3), 1'b1, 1'b1, -1);
         end else if (pick < 86) begin
            send_packet(field_lead(second_field), $urandom_range(5, 60),
                        $urandom_range(1, 70), 1'b1, 1'b1, -1);
         end else if (pick < 90) begin
            len = $urandom_range(5, 40);
            send_packet(field_lead(second_field), len, $urandom_range(1, len), 1'b1, 1'b0, -1);
         end else if (pick < 95) begin
            send_packet(BYTE_W'($urandom), $urandom_range(0, 4095), $urandom_range(1, 6),
                        1'b0, $urandom_range(0, 1), -1);
         end else begin
            send_packet(BYTE_W'($urandom), $urandom_range(0, 4095), $urandom_range(1, 8),
                        $urandom_range(0, 1), $urandom_range(0, 1), -1);
         end
      end
   endtask

   initial begin
      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_LINE_BYTES;
      csr_write_data    <= '0;
      req.valid         <= 1'b0;
      req.data_byte     <= '0;
      req.packet_start  <= 1'b0;
      req.packet_end    <= 1'b0;
      req.packet_length <= '0;
      bytes_sent   = 0;
      burst_left   = 0;
      second_field = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_packet(MARK_FIELD2_A, 6, 6, 1'b1, 1'b1, 8'hFF);
      send_packet(8'h00, 7, 7, 1'b1, 1'b1, 8'h00);
      send_packet(MARK_FIELD2_B, CTRL_PKT_LEN, 5, 1'b1, 1'b1, -1);
      send_packet(MARK_FIELD2_C, 0, 1, 1'b1, 1'b1, -1);
      send_packet(8'h80, PAYLOAD_OFFSET, 2, 1'b1, 1'b1, -1);
      send_packet(8'hFF, 4095, 3, 1'b1, 1'b0, -1);
      send_packet(8'h5A, 4095, 2, 1'b0, 1'b1, -1);
      send_packet(MARK_FIELD2_A, 1, 1, 1'b1, 1'b1, -1);

      reconfigure(16, 8);
      random_traffic(80);
      reconfigure(MIN_LINE_BYTES, MIN_FRAME_LINES);
      random_traffic(60);
      reconfigure(MAX_LINE_BYTES, MAX_FRAME_LINES);
      random_traffic(60);
      reconfigure(24, 6);
      random_traffic(60);
      reconfigure(5, 9);
      random_traffic(60);
      reconfigure(0, 0);
      random_traffic(50);
      reconfigure(4095, 4095);
      random_traffic(50);

      // run one long packet over the shortest lines
      reconfigure(1, MAX_FRAME_LINES);
      send_packet(MARK_FIELD2_B, 4095, 200, 1'b1, 1'b0, -1);
      send_packet(BYTE_W'($urandom), 4095, 1, 1'b0, 1'b1, -1);

      repeat (3) begin
         reconfigure($urandom_range(2, 40), $urandom_range(2, 16));
         random_traffic(50);
      end

      settle();
      if (board.pending() != 0)
         board.report("expected writes never arrived");
      if (board.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: interlaced_field_weave_assembler_top.f
rtl/ifwa_pkg.sv
rtl/ifwa_if.sv
rtl/ifwa_rem.sv
rtl/ifwa_datapath.sv
rtl/ifwa_ctrl.sv
rtl/interlaced_field_weave_assembler_top.sv
tb/sv/testbench.sv
